/* design/estdeg_pkg.sv */
// ----------------------------------------------------------------------------
// estdeg_pkg
// Types and codes shared by the emergency-stop and degradation supervisor.
// ----------------------------------------------------------------------------
package estdeg_pkg;

  // Request kinds
  localparam logic [1:0] REQ_ALERT   = 2'd0;
  localparam logic [1:0] REQ_STOP    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  // Alert severities that have an effect
  localparam logic [2:0] LVL_WARN  = 3'd2;
  localparam logic [2:0] LVL_ERROR = 3'd3;
  localparam logic [2:0] LVL_FATAL = 3'd4;

  // Degradation modes
  localparam logic [2:0] DM_FULL      = 3'd0;
  localparam logic [2:0] DM_REDUCED   = 3'd1;
  localparam logic [2:0] DM_SENSORS   = 3'd2;
  localparam logic [2:0] DM_HALT      = 3'd3;
  localparam logic [2:0] DM_EMERGENCY = 3'd4;

  // Stop sources
  localparam logic [2:0] SRC_SOFTWARE = 3'd0;
  localparam logic [2:0] SRC_REMOTE   = 3'd2;

  // Q1.15 speed constants
  localparam logic [15:0] Q15_ONE  = 16'h8000;
  localparam logic [15:0] Q15_HALF = 16'h4000;
  localparam logic [15:0] Q15_ZERO = 16'h0000;

  // Width of the counter totals on the result
  localparam int TOTAL_W = 16;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] alert_level;
    logic       source_is_sensor;
    logic [2:0] stop_source;
    logic       hw_release_ok;
  } estdeg_in_t;

  typedef struct packed {
    logic                request_ok;
    logic                stop_latched;
    logic [2:0]          latched_source;
    logic [2:0]          degrade_mode;
    logic [15:0]         speed_limit;
    logic                safe_flag;
    logic                hw_stop_pulse;
    logic                stop_motion_pulse;
    logic [TOTAL_W-1:0]  stop_total;
    logic [TOTAL_W-1:0]  alert_total;
  } estdeg_out_t;

endpackage

/* design/estop_degradation_supervisor_core.sv */
// ----------------------------------------------------------------------------
// estop_degradation_supervisor_core
// Emergency-stop latch and degradation-mode supervisor, one request per item.
// ----------------------------------------------------------------------------
// Each input item is one request: raise an alert, request an emergency stop or
// request a release. The supervisor state (stop latch, latched source,
// degradation mode and the two saturating counters) is updated at the edge the
// item is accepted, and the result item carrying the new status and the Q1.15
// speed limit appears in the result register on the following cycle. The block
// takes one item per cycle; the single result register sets this figure, so a
// new item is accepted whenever that register is empty or being emptied in the
// same cycle. The speed fraction for the sensor-degraded mode is written
// through the cfg_ port (always ready) and must only be changed while no item
// is in flight. COUNT_WIDTH sets the width of the internal counters; the totals
// on the result carry their low 16 bits.
module estop_degradation_supervisor_core
  import estdeg_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  estdeg_in_t  in_item,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output estdeg_out_t out_item,
  // configuration: sensor-degraded speed fraction
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam logic [COUNT_WIDTH-1:0] CNT_CAP = {COUNT_WIDTH{1'b1}};

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == CNT_CAP) ? c : c + 1'b1;
  endfunction

  // supervisor state
  logic                   latch_r,  latch_nxt;
  logic [2:0]             src_r,    src_nxt;
  logic [2:0]             dm_r,     dm_nxt;
  logic [COUNT_WIDTH-1:0] stop_r,   stop_nxt;
  logic [COUNT_WIDTH-1:0] alert_r,  alert_nxt;
  logic [15:0]            frac_r;

  // result register
  logic        out_valid_r;
  estdeg_out_t out_r, out_nxt;

  logic                   accept;
  logic [COUNT_WIDTH-1:0] alert_one;
  logic                   ok;
  logic                   hw_pulse;
  logic                   motion_pulse;
  logic [15:0]            speed;
  logic [TOTAL_W-1:0]     stop_tot;
  logic [TOTAL_W-1:0]     alert_tot;

  // result register empties or drains this cycle -> room for the next item
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign alert_one = sat_inc(alert_r);

  // request decode and state update
  always_comb begin
    latch_nxt    = latch_r;
    src_nxt      = src_r;
    dm_nxt       = dm_r;
    stop_nxt     = stop_r;
    alert_nxt    = alert_r;
    ok           = 1'b1;
    hw_pulse     = 1'b0;
    motion_pulse = 1'b0;
    unique case (in_item.mode)
      REQ_ALERT: begin
        alert_nxt = alert_one;
        if (in_item.alert_level == LVL_FATAL) begin
          dm_nxt = DM_EMERGENCY;
          if (!latch_r) begin
            // new latch also reports its own stop alert
            latch_nxt = 1'b1;
            src_nxt   = SRC_SOFTWARE;
            stop_nxt  = sat_inc(stop_r);
            alert_nxt = sat_inc(alert_one);
            hw_pulse  = 1'b1;
          end
        end else if (in_item.alert_level == LVL_ERROR) begin
          dm_nxt       = in_item.source_is_sensor ? DM_SENSORS : DM_HALT;
          motion_pulse = 1'b1;
        end else if (in_item.alert_level == LVL_WARN) begin
          if (dm_r == DM_FULL) begin
            dm_nxt = DM_REDUCED;
          end
        end
      end
      REQ_STOP: begin
        if (!latch_r) begin
          latch_nxt = 1'b1;
          src_nxt   = in_item.stop_source;
          stop_nxt  = sat_inc(stop_r);
          alert_nxt = alert_one;
          dm_nxt    = DM_EMERGENCY;
          hw_pulse  = 1'b1;
        end
      end
      REQ_RELEASE: begin
        if (latch_r) begin
          if (src_r == SRC_REMOTE || !in_item.hw_release_ok) begin
            ok = 1'b0;
          end else begin
            latch_nxt = 1'b0;
            src_nxt   = SRC_SOFTWARE;
            dm_nxt    = DM_FULL;
          end
        end
      end
      default: begin
        // unused request code: no effect
      end
    endcase
  end

  // speed limit by mode; configured fraction clamped to 1.0
  always_comb begin
    unique case (dm_nxt)
      DM_FULL:    speed = Q15_ONE;
      DM_REDUCED: speed = Q15_HALF;
      DM_SENSORS: speed = (frac_r > Q15_ONE) ? Q15_ONE : frac_r;
      default:    speed = Q15_ZERO;
    endcase
  end

  // totals carry the low bits of the counters
  generate
    if (COUNT_WIDTH >= TOTAL_W) begin : g_tot_trunc
      assign stop_tot  = stop_nxt[TOTAL_W-1:0];
      assign alert_tot = alert_nxt[TOTAL_W-1:0];
    end else begin : g_tot_ext
      assign stop_tot  = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, stop_nxt};
      assign alert_tot = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, alert_nxt};
    end
  endgenerate

  always_comb begin
    out_nxt.request_ok        = ok;
    out_nxt.stop_latched      = latch_nxt;
    out_nxt.latched_source    = latch_nxt ? src_nxt : SRC_SOFTWARE;
    out_nxt.degrade_mode      = dm_nxt;
    out_nxt.speed_limit       = speed;
    out_nxt.safe_flag         = !latch_nxt && (dm_nxt < DM_HALT);
    out_nxt.hw_stop_pulse     = hw_pulse;
    out_nxt.stop_motion_pulse = motion_pulse;
    out_nxt.stop_total        = stop_tot;
    out_nxt.alert_total       = alert_tot;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r     <= 1'b0;
      src_r       <= SRC_SOFTWARE;
      dm_r        <= DM_FULL;
      stop_r      <= '0;
      alert_r     <= '0;
      frac_r      <= Q15_ONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        frac_r <= cfg_data;
      end
      if (accept) begin
        latch_r     <= latch_nxt;
        src_r       <= src_nxt;
        dm_r        <= dm_nxt;
        stop_r      <= stop_nxt;
        alert_r     <= alert_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for estop_degradation_supervisor_core.
// Requests go in through a queue-fed driver under random idling. A local
// model of the latch, degradation mode and counters predicts each result item,
// and a monitor checks every field. The speed fraction is rewritten between
// phases, including both extremes. The remote-shutdown latch can never be
// released, so it is only exercised in the last phase.
// ----------------------------------------------------------------------------
module testbench
  import estdeg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_AT  = 200;  // items taken before the long receiver hold-off
  localparam int HOLD_LEN = 400;  // cycles of that hold-off
  localparam int IN_W     = $bits(estdeg_in_t);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  estdeg_in_t  in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  estdeg_out_t out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  estop_degradation_supervisor_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Requests waiting to be offered, and result items still owed by the block
  estdeg_in_t  req_backlog[$];
  estdeg_out_t due_results[$];

  int   n_faults  = 0;
  int   n_taken   = 0;   // items accepted, updated at the edge only
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic calm      = 1'b0; // set from the sequencer at a falling edge: no idling

  // Shadow of the supervisor: state after reset, plus the speed fraction
  logic        sv_latched = 1'b0;
  logic [2:0]  sv_src     = SRC_SOFTWARE;
  logic [2:0]  sv_mode    = DM_FULL;
  logic [15:0] sv_stops   = '0;
  logic [15:0] sv_alerts  = '0;
  logic [15:0] frac_cfg   = Q15_ONE;

  // A new stop latches once; it also counts as a FATAL alert
  function automatic logic latch_new(input logic [2:0] src);
    if (sv_latched) return 1'b0;
    sv_latched = 1'b1;
    sv_src     = src;
    if (sv_stops != '1) sv_stops++;
    if (sv_alerts != '1) sv_alerts++;
    sv_mode = DM_EMERGENCY;
    return 1'b1;
  endfunction

  // Apply one request to the shadow state, return the result item it yields
  function automatic estdeg_out_t step_supervisor(input estdeg_in_t rq);
    estdeg_out_t r;
    logic ok, hw_p, mo_p;
    ok = 1'b1;
    hw_p = 1'b0;
    mo_p = 1'b0;
    case (rq.mode)
      REQ_ALERT: begin
        if (sv_alerts != '1) sv_alerts++;
        if (rq.alert_level == LVL_FATAL) begin
          sv_mode = DM_EMERGENCY;
          hw_p = latch_new(SRC_SOFTWARE);
        end else if (rq.alert_level == LVL_ERROR) begin
          // overwrites whatever mode is current, EMERGENCY included
          sv_mode = rq.source_is_sensor ? DM_SENSORS : DM_HALT;
          mo_p = 1'b1;
        end else if (rq.alert_level == LVL_WARN) begin
          if (sv_mode < DM_REDUCED) sv_mode = DM_REDUCED;
        end
      end
      REQ_STOP: hw_p = latch_new(rq.stop_source);
      REQ_RELEASE: begin
        if (sv_latched) begin
          if (sv_src == SRC_REMOTE || !rq.hw_release_ok) begin
            ok = 1'b0;
          end else begin
            sv_latched = 1'b0;
            sv_src = SRC_SOFTWARE;
            sv_mode = DM_FULL;
          end
        end
      end
      default: ;  // unused request code: no effect
    endcase
    r.request_ok     = ok;
    r.stop_latched   = sv_latched;
    r.latched_source = sv_latched ? sv_src : SRC_SOFTWARE;
    r.degrade_mode   = sv_mode;
    case (sv_mode)
      DM_FULL:    r.speed_limit = Q15_ONE;
      DM_REDUCED: r.speed_limit = Q15_HALF;
      DM_SENSORS: r.speed_limit = (frac_cfg > Q15_ONE) ? Q15_ONE : frac_cfg;
      default:    r.speed_limit = Q15_ZERO;
    endcase
    r.safe_flag         = !sv_latched && (sv_mode < DM_HALT);
    r.hw_stop_pulse     = hw_p;
    r.stop_motion_pulse = mo_p;
    r.stop_total        = sv_stops;
    r.alert_total       = sv_alerts;
    return r;
  endfunction

  function automatic estdeg_in_t mk_req(input logic [1:0] md, input logic [2:0] lvl,
                                        input logic sens, input logic [2:0] src,
                                        input logic hw_ok);
    estdeg_in_t q;
    q.mode = md;
    q.alert_level = lvl;
    q.source_is_sensor = sens;
    q.stop_source = src;
    q.hw_release_ok = hw_ok;
    return q;
  endfunction

  // Append one request to the tail of the backlog
  function automatic void add_req(input estdeg_in_t q);
    req_backlog.insert(req_backlog.size(), q);
  endfunction

  // Random requests. A remote-shutdown stop that latches can never be
  // cleared, so stop requests only carry that source when allowed.
  task automatic queue_random(input int count, input bit allow_remote);
    estdeg_in_t q;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      q = IN_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 45)      q.mode = REQ_ALERT;
      else if (pick < 67) q.mode = REQ_STOP;
      else if (pick < 95) q.mode = REQ_RELEASE;
      else                q.mode = 2'd3;
      // lean towards the levels that act
      if ($urandom_range(99) < 40) q.alert_level = LVL_WARN + 3'($urandom_range(2));
      q.hw_release_ok = ($urandom_range(99) < 80);
      if (q.mode == REQ_STOP && !allow_remote && q.stop_source == SRC_REMOTE)
        q.stop_source = 3'($urandom_range(7, 3));
      add_req(q);
    end
  endtask

  // Wait until every offered item has been taken and answered, then let the
  // block settle. Sampled at falling edges to stay clear of the edge activity.
  task automatic drain_results();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fraction(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    frac_cfg = v;
    cfg_valid <= 1'b0;
  endtask

  // Driver: an item is taken at an edge where valid and ready are both high;
  // valid holds with its payload until then.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.insert(due_results.size(), step_supervisor(in_item));
        n_taken <= n_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
          in_item  <= req_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off while the sender keeps offering: the result
  // register fills and the input stalls.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_taken >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 12);
  end

  // Monitor: every result item against the oldest prediction
  always @(posedge clk) begin : result_check
    estdeg_out_t want;
    logic [9:0]  diff;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        n_faults++;
        if (n_faults <= 10) $display("result item with nothing predicted: %h", out_item);
      end else begin
        want = due_results.pop_front();
        diff = {out_item.request_ok        !== want.request_ok,
                out_item.stop_latched      !== want.stop_latched,
                out_item.latched_source    !== want.latched_source,
                out_item.degrade_mode      !== want.degrade_mode,
                out_item.speed_limit       !== want.speed_limit,
                out_item.safe_flag         !== want.safe_flag,
                out_item.hw_stop_pulse     !== want.hw_stop_pulse,
                out_item.stop_motion_pulse !== want.stop_motion_pulse,
                out_item.stop_total        !== want.stop_total,
                out_item.alert_total       !== want.alert_total};
        if (diff != '0) begin
          n_faults++;
          if (n_faults <= 10)
            $display("mismatch (exp/got): ok %b/%b latched %b/%b src %0d/%0d ",
                     want.request_ok, out_item.request_ok,
                     want.stop_latched, out_item.stop_latched,
                     want.latched_source, out_item.latched_source,
                     "mode %0d/%0d speed %h/%h safe %b/%b hwstop %b/%b ",
                     want.degrade_mode, out_item.degrade_mode,
                     want.speed_limit, out_item.speed_limit,
                     want.safe_flag, out_item.safe_flag,
                     want.hw_stop_pulse, out_item.hw_stop_pulse,
                     "motion %b/%b stops %0d/%0d alerts %0d/%0d",
                     want.stop_motion_pulse, out_item.stop_motion_pulse,
                     want.stop_total, out_item.stop_total,
                     want.alert_total, out_item.alert_total);
        end
      end
    end
  end

  // Sequencer
  initial begin
    logic [15:0] frac_set [6];
    frac_set = '{16'h0000, 16'hFFFF, 16'h8000, 16'h8001, 16'h7FFF, 16'h0000};
    frac_set[5] = 16'($urandom);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, speed fraction at its reset value
    add_req(mk_req(REQ_ALERT, 3'd0, 1'b0, 3'd7, 1'b0));       // OK
    add_req(mk_req(REQ_ALERT, 3'd1, 1'b1, 3'd0, 1'b1));       // INFO
    add_req(mk_req(REQ_ALERT, LVL_WARN, 1'b0, 3'd0, 1'b1));   // FULL -> REDUCED
    add_req(mk_req(REQ_ALERT, LVL_WARN, 1'b0, 3'd0, 1'b1));   // stays REDUCED
    add_req(mk_req(REQ_ALERT, LVL_ERROR, 1'b1, 3'd0, 1'b1));  // sensor-degraded
    add_req(mk_req(REQ_ALERT, LVL_WARN, 1'b1, 3'd0, 1'b1));   // no change
    add_req(mk_req(REQ_ALERT, LVL_ERROR, 1'b0, 3'd0, 1'b1));  // halted
    add_req(mk_req(REQ_RELEASE, 3'd0, 1'b0, 3'd0, 1'b1));     // nothing latched
    add_req(mk_req(REQ_ALERT, 3'd5, 1'b1, 3'd7, 1'b0));       // unused levels
    add_req(mk_req(REQ_ALERT, 3'd6, 1'b0, 3'd7, 1'b1));
    add_req(mk_req(REQ_ALERT, 3'd7, 1'b1, 3'd7, 1'b1));
    add_req(mk_req(2'd3, 3'd7, 1'b1, 3'd7, 1'b1));            // unused request
    add_req(mk_req(REQ_ALERT, LVL_FATAL, 1'b0, 3'd5, 1'b1));  // latches, +2 alerts
    add_req(mk_req(REQ_ALERT, LVL_FATAL, 1'b1, 3'd0, 1'b1));  // already latched
    add_req(mk_req(REQ_STOP, 3'd0, 1'b0, 3'd5, 1'b1));        // ignored while latched
    add_req(mk_req(REQ_ALERT, LVL_ERROR, 1'b1, 3'd0, 1'b1));  // overwrites EMERGENCY
    add_req(mk_req(REQ_RELEASE, 3'd0, 1'b0, 3'd0, 1'b0));     // hardware refuses
    add_req(mk_req(REQ_RELEASE, 3'd0, 1'b0, 3'd0, 1'b1));     // released
    add_req(mk_req(REQ_STOP, 3'd0, 1'b0, 3'd6, 1'b1));        // odd source kept
    add_req(mk_req(REQ_RELEASE, 3'd7, 1'b1, 3'd7, 1'b1));
    add_req(mk_req(REQ_STOP, 3'd0, 1'b0, 3'd7, 1'b0));
    add_req(mk_req(REQ_ALERT, LVL_WARN, 1'b0, 3'd0, 1'b1));   // EMERGENCY kept
    add_req(mk_req(REQ_RELEASE, 3'd0, 1'b0, 3'd0, 1'b1));
    add_req(mk_req(REQ_STOP, 3'd0, 1'b0, 3'd1, 1'b1));        // button
    add_req(mk_req(REQ_RELEASE, 3'd0, 1'b0, 3'd0, 1'b1));
    drain_results();

    // Random phases across speed fractions; the third runs without idling
    for (int i = 0; i < 6; i++) begin
      write_fraction(frac_set[i]);
      @(negedge clk);
      calm = (i == 2);
      queue_random(110, 1'b0);
      drain_results();
      @(negedge clk);
      calm = 1'b0;
    end

    // Remote shutdown latches for good: releases are refused from here on
    write_fraction(16'h7FFF);
    @(negedge clk);
    add_req(mk_req(REQ_STOP, 3'd0, 1'b0, SRC_REMOTE, 1'b1));
    add_req(mk_req(REQ_RELEASE, 3'd0, 1'b0, 3'd0, 1'b1));
    add_req(mk_req(REQ_RELEASE, 3'd0, 1'b0, 3'd0, 1'b0));
    add_req(mk_req(REQ_ALERT, LVL_ERROR, 1'b1, 3'd0, 1'b1));
    queue_random(80, 1'b1);
    drain_results();

    if (n_faults == 0 && due_results.size() == 0) begin
      $display("estop_degradation_supervisor_core regression: pass");
    end else begin
      $display("estop_degradation_supervisor_core regression: fail");
    end
    $finish;
  end

  // Watchdog, several times the slowest expected run
  initial begin
    #1_000_000;
    $display("estop_degradation_supervisor_core regression: fail");
    $finish;
  end

endmodule

/* sim.f */
design/estdeg_pkg.sv
design/estop_degradation_supervisor_core.sv
bench/testbench.sv
